### rtl/core/rv64ie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64ie_pkg: shared types and constants for the RV64I immediate ALU unit
// Instruction field codes, register file geometry and result bundle.
// ----------------------------------------------------------------------------
package rv64ie_pkg;

	localparam int XLEN      = 64;
	localparam int REG_COUNT = 32;
	localparam int REG_AW    = 5;
	localparam int INST_W    = 32;

	localparam logic [XLEN-1:0] STACK_TOP_RESET = 64'h0000_0000_8010_0000;
	localparam logic [REG_AW-1:0] STACK_REG     = 5'd2;
	localparam logic [REG_AW-1:0] ZERO_REG      = 5'd0;

	localparam logic [6:0] OPC_OP_IMM = 7'h13;

	typedef enum logic [2:0] {
		F3_ADDI  = 3'd0,
		F3_SLLI  = 3'd1,
		F3_SLTI  = 3'd2,
		F3_SLTIU = 3'd3,
		F3_XORI  = 3'd4,
		F3_SRXI  = 3'd5,
		F3_ORI   = 3'd6,
		F3_ANDI  = 3'd7
	} funct3_t;

	localparam logic [5:0] TOP6_SRLI = 6'h00;
	localparam logic [5:0] TOP6_SRAI = 6'h10;

	typedef struct packed {
		logic [REG_AW-1:0] dest;
		logic [XLEN-1:0]   value;
		logic              wrote;
		logic              unknown;
	} result_t;

	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] addr;
		logic [XLEN-1:0]   data;
	} wr_req_t;

endpackage

### rtl/core/rv64_immediate_alu_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64_immediate_alu_execute_unit: RV64I OP-IMM execute with register file
//
//  channel | dir | bits                         | meaning
//  s_*     | in  | tdata[31:0]                  | instruction word
//  m_*     | out | tdata[4:0], [68:5]; tuser[1:0]| dest, value; wrote, unknown
//
// One item per cycle while the result side takes it. An item is latched in
// the input register, then decoded, executed and written back to the register
// file as it moves to the result register, so the next item reads the updated
// file with no stall.
// Reset clears both valid flags and loads x2 with the stack top reset value.
// A stalled result holds both stages; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module rv64_immediate_alu_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // instruction[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // dest_index[4:0], write_value[68:5], zero[71:69]
	output logic [1:0]  m_tuser    // wrote[0], unknown_opcode[1]
);

	logic                                valid_s1;
	logic [rv64ie_pkg::INST_W-1:0]       inst_s1;
	logic                                valid_s2;
	rv64ie_pkg::result_t                 result_s2;
	logic                                adv_s2;
	logic                                move_s1;
	logic [rv64ie_pkg::XLEN-1:0]         rs1_val;
	rv64ie_pkg::result_t                 result;
	rv64ie_pkg::wr_req_t                 wr_req;

	assign adv_s2   = !valid_s2 || m_tready;
	assign move_s1  = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			inst_s1 <= s_tdata;
		end
	end

	rv64ie_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (inst_s1[19:15]),
		.rd_data (rs1_val),
		.wr_req  (wr_req)
	);

	rv64ie_alu u_alu (
		.inst    (inst_s1),
		.rs1_val (rs1_val),
		.result  (result)
	);

	always_comb begin
		wr_req.en   = move_s1 && result.wrote;
		wr_req.addr = result.dest;
		wr_req.data = result.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, result_s2.value, result_s2.dest};
	assign m_tuser  = {result_s2.unknown, result_s2.wrote};

endmodule

### rtl/core/rv64ie_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64ie_regfile: 32 x 64-bit integer register file
// One combinational read port with x0 tied to zero, one clocked write port.
// ----------------------------------------------------------------------------
module rv64ie_regfile (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [rv64ie_pkg::REG_AW-1:0]    rd_addr,
	output logic [rv64ie_pkg::XLEN-1:0]      rd_data,
	input  rv64ie_pkg::wr_req_t              wr_req
);

	logic [rv64ie_pkg::XLEN-1:0] regs_q [rv64ie_pkg::REG_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rv64ie_pkg::REG_COUNT; i++) begin
				regs_q[i] <= (i == int'(rv64ie_pkg::STACK_REG)) ?
					rv64ie_pkg::STACK_TOP_RESET : '0;
			end
		end else if (wr_req.en && (wr_req.addr != rv64ie_pkg::ZERO_REG)) begin
			regs_q[wr_req.addr] <= wr_req.data;
		end
	end

	assign rd_data = (rd_addr == rv64ie_pkg::ZERO_REG) ? '0 : regs_q[rd_addr];

endmodule

### rtl/core/rv64ie_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64ie_alu: OP-IMM decode and execute
// Decodes one instruction word and computes its result from operand rs1.
// ----------------------------------------------------------------------------
module rv64ie_alu (
	input  logic [rv64ie_pkg::INST_W-1:0] inst,
	input  logic [rv64ie_pkg::XLEN-1:0]   rs1_val,
	output rv64ie_pkg::result_t           result
);

	logic [6:0]                  opcode;
	rv64ie_pkg::funct3_t         f3;
	logic [5:0]                  top6;
	logic [5:0]                  shamt;
	logic [rv64ie_pkg::REG_AW-1:0] rd;
	logic [rv64ie_pkg::XLEN-1:0] imm;
	logic [rv64ie_pkg::XLEN-1:0] res;
	logic                        ok;
	logic                        is_opimm;

	assign opcode   = inst[6:0];
	assign f3       = rv64ie_pkg::funct3_t'(inst[14:12]);
	assign top6     = inst[31:26];
	assign shamt    = inst[25:20];
	assign rd       = inst[11:7];
	assign imm      = {{(rv64ie_pkg::XLEN-12){inst[31]}}, inst[31:20]};
	assign is_opimm = (opcode == rv64ie_pkg::OPC_OP_IMM);

	always_comb begin
		res = '0;
		ok  = 1'b1;
		unique case (f3)
			rv64ie_pkg::F3_ADDI:  res = rs1_val + imm;
			rv64ie_pkg::F3_SLLI:  res = rs1_val << shamt;
			rv64ie_pkg::F3_SLTI:  res = {63'd0, ($signed(rs1_val) < $signed(imm))};
			rv64ie_pkg::F3_SLTIU: res = {63'd0, (rs1_val < imm)};
			rv64ie_pkg::F3_XORI:  res = rs1_val ^ imm;
			rv64ie_pkg::F3_SRXI: begin
				if (top6 == rv64ie_pkg::TOP6_SRLI) begin
					res = rs1_val >> shamt;
				end else if (top6 == rv64ie_pkg::TOP6_SRAI) begin
					res = $unsigned($signed(rs1_val) >>> shamt);
				end else begin
					ok = 1'b0;
				end
			end
			rv64ie_pkg::F3_ORI:   res = rs1_val | imm;
			rv64ie_pkg::F3_ANDI:  res = rs1_val & imm;
			default:              ok = 1'b0;
		endcase
	end

	always_comb begin
		result.dest    = rd;
		result.unknown = !is_opimm;
		result.wrote   = is_opimm && ok && (rd != rv64ie_pkg::ZERO_REG);
		result.value   = result.wrote ? res : '0;
	end

endmodule

### test/op_imm_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// op_imm_result_checker: prediction and scoreboard for the OP-IMM execute unit
// Keeps a shadow 32 x 64-bit register file, works out the result of every
// accepted instruction and compares each returned item field by field with
// the oldest outstanding prediction. Reports the failure count and the number
// of results still owed.
// ----------------------------------------------------------------------------
module op_imm_result_checker
	import rv64ie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // instruction[31:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // dest_index[4:0], write_value[68:5], zero[71:69]
	input  logic [1:0]  m_tuser,   // wrote[0], unknown_opcode[1]
	output int          fail_count,
	output int          outstanding
);

	logic [XLEN-1:0] gpr [REG_COUNT];
	result_t         owed_q [$];
	result_t         got;
	result_t         want;
	result_t         next;

	function automatic result_t predict_op_imm(input logic [31:0] insn);
		result_t         r;
		logic [XLEN-1:0] src;
		logic [XLEN-1:0] imm;
		logic [XLEN-1:0] res;
		logic [5:0]      shamt;
		logic            ok;
		funct3_t         f3;
		r = '0;
		r.dest = insn[11:7];
		if (insn[6:0] != OPC_OP_IMM) begin
			r.unknown = 1'b1;
			return r;
		end
		src   = (insn[19:15] == ZERO_REG) ? '0 : gpr[insn[19:15]];
		imm   = {{52{insn[31]}}, insn[31:20]};
		shamt = insn[25:20];
		ok    = 1'b1;
		res   = '0;
		f3    = funct3_t'(insn[14:12]);
		case (f3)
			F3_ADDI:  res = src + imm;
			F3_SLLI:  res = src << shamt;
			F3_SLTI:  res = ($signed(src) < $signed(imm)) ? 64'd1 : 64'd0;
			F3_SLTIU: res = (src < imm) ? 64'd1 : 64'd0;
			F3_XORI:  res = src ^ imm;
			F3_SRXI: begin
				if (insn[31:26] == TOP6_SRLI)
					res = src >> shamt;
				else if (insn[31:26] == TOP6_SRAI)
					res = $signed(src) >>> shamt;
				else
					ok = 1'b0;
			end
			F3_ORI:   res = src | imm;
			default:  res = src & imm;
		endcase
		if (ok && r.dest != ZERO_REG) begin
			r.wrote = 1'b1;
			r.value = res;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++)
				gpr[i] = '0;
			gpr[STACK_REG] = STACK_TOP_RESET;
			owed_q.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.dest    = m_tdata[4:0];
				got.value   = m_tdata[68:5];
				got.wrote   = m_tuser[0];
				got.unknown = m_tuser[1];
				if (owed_q.size() == 0) begin
					$error("result item with nothing outstanding: dest %0d value %h",
						got.dest, got.value);
					fail_count++;
				end else begin
					want = owed_q.pop_front();
					if (got.dest !== want.dest) begin
						$error("dest_index: expected %0d, got %0d", want.dest, got.dest);
						fail_count++;
					end
					if (got.value !== want.value) begin
						$error("write_value: expected %h, got %h", want.value, got.value);
						fail_count++;
					end
					if (got.wrote !== want.wrote) begin
						$error("wrote: expected %0b, got %0b", want.wrote, got.wrote);
						fail_count++;
					end
					if (got.unknown !== want.unknown) begin
						$error("unknown_opcode: expected %0b, got %0b",
							want.unknown, got.unknown);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				next = predict_op_imm(s_tdata);
				if (next.wrote)
					gpr[next.dest] = next.value;
				owed_q.push_back(next);
			end
			outstanding = owed_q.size();
		end
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for rv64_immediate_alu_execute_unit
// Sends a directed set of OP-IMM and bad-opcode corner cases, then random instruction words,
// mostly well-formed OP-IMM with random operands plus raw noise, under random
// gaps on the input and random back-pressure on the result side. Checking is
// done by the checker instance; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import rv64ie_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;
	int          fail_count;
	int          outstanding;
	logic        calm;
	int          idle_cycles;

	rv64_immediate_alu_execute_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	op_imm_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] enc_op_imm(input funct3_t f3, input logic [4:0] rd,
			input logic [4:0] rs1, input logic [11:0] imm);
		return {imm, rs1, f3, rd, OPC_OP_IMM};
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] rand_insn();
		funct3_t    f3;
		logic [11:0] imm;
		int         sel;
		if ($urandom_range(0, 99) < 12)
			return $urandom();
		f3  = funct3_t'($urandom_range(0, 7));
		imm = 12'($urandom());
		if (f3 == F3_SRXI) begin
			sel = $urandom_range(0, 9);
			if (sel < 5)
				imm[11:6] = TOP6_SRLI;
			else if (sel < 9)
				imm[11:6] = TOP6_SRAI;
		end
		return enc_op_imm(f3, 5'($urandom()), 5'($urandom()), imm);
	endfunction

	task automatic send_insn(input logic [31:0] w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = w;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// result side back-pressure
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_tready = 1'b0;
				hold--;
			end else begin
				m_tready = 1'b1;
				hold = pick_gap();
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [31:0] directed [$];
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		calm     = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		directed.push_back(enc_op_imm(F3_ADDI, 5'd1, 5'd0, 12'h7ff));
		directed.push_back(enc_op_imm(F3_ADDI, 5'd3, 5'd0, 12'h800));
		directed.push_back(enc_op_imm(F3_ADDI, 5'd31, 5'd0, 12'hfff));
		directed.push_back(enc_op_imm(F3_ADDI, 5'd5, STACK_REG, 12'h000));
		directed.push_back(enc_op_imm(F3_SLLI, 5'd6, 5'd31, {TOP6_SRLI, 6'd63}));
		directed.push_back(enc_op_imm(F3_SLLI, 5'd7, 5'd1, {6'h3f, 6'd40}));
		directed.push_back(enc_op_imm(F3_SRXI, 5'd8, 5'd31, {TOP6_SRLI, 6'd63}));
		directed.push_back(enc_op_imm(F3_SRXI, 5'd9, 5'd6, {TOP6_SRAI, 6'd63}));
		directed.push_back(enc_op_imm(F3_SRXI, 5'd10, 5'd5, {TOP6_SRAI, 6'd4}));
		directed.push_back(enc_op_imm(F3_SRXI, 5'd11, 5'd1, {6'h20, 6'd1}));
		directed.push_back(enc_op_imm(F3_SLTI, 5'd12, 5'd3, 12'h7ff));
		directed.push_back(enc_op_imm(F3_SLTI, 5'd13, 5'd1, 12'h800));
		directed.push_back(enc_op_imm(F3_SLTIU, 5'd14, 5'd0, 12'hfff));
		directed.push_back(enc_op_imm(F3_SLTIU, 5'd15, 5'd31, 12'hfff));
		directed.push_back(enc_op_imm(F3_XORI, 5'd16, STACK_REG, 12'hfff));
		directed.push_back(enc_op_imm(F3_ORI, 5'd17, 5'd3, 12'h555));
		directed.push_back(enc_op_imm(F3_ANDI, 5'd18, 5'd31, 12'h800));
		directed.push_back(enc_op_imm(F3_ADDI, ZERO_REG, 5'd31, 12'h001));
		directed.push_back(32'h0000_0033);
		directed.push_back(32'hffff_ffff);
		directed.push_back(32'h0000_0000);
		directed.push_back(enc_op_imm(F3_ADDI, 5'd31, 5'd31, 12'h001));
		directed.push_back(enc_op_imm(F3_SRXI, ZERO_REG, 5'd9, {TOP6_SRAI, 6'd0}));

		foreach (directed[i])
			send_insn(directed[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0)
				calm = ($urandom_range(0, 3) == 0);
			send_insn(rand_insn());
		end
		s_tvalid = 1'b0;
		calm     = 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
rtl/core/rv64ie_pkg.sv
rtl/core/rv64ie_regfile.sv
rtl/core/rv64ie_alu.sv
rtl/core/rv64_immediate_alu_execute_unit.sv
test/op_imm_result_checker.sv
test/tb_top.sv
